// File: design/mub_pkg.sv
// mub_pkg: shared types, constants and helpers for the mcu upsample block
// used by mub_front, mub_back, the top level and the testbench, depends on nothing
package mub_pkg;

  localparam int unsigned MaxBlocks = 4;
  localparam int unsigned BlockSize = 64;
  localparam int unsigned BlockSide = 8;
  localparam int unsigned SampleW   = 8;
  localparam int unsigned CfgW      = 3;
  localparam int unsigned CfgIdxW   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHFactor      = 2'd0,
    CfgVFactor      = 2'd1,
    CfgBlocksAcross = 2'd2,
    CfgBlocksDown   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ModeLoad = 1'b0,
    ModePull = 1'b1
  } mode_e;

  typedef struct packed {
    logic               mode;
    logic [SampleW-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic [SampleW-1:0] sample_out;
    logic               last;
  } out_item_t;

  // command from front to back, the store address travels beside it
  typedef struct packed {
    logic               is_read;
    logic               zero;
    logic               last;
    logic [SampleW-1:0] data;
  } cmd_t;

  localparam int unsigned CmdW = $bits(cmd_t);

  // effective factor: 0 acts as 1, above 4 acts as 4
  function automatic logic [CfgW-1:0] eff(input logic [CfgW-1:0] v);
    logic [CfgW-1:0] r;
    r = v;
    if (v == 3'd0) begin
      r = 3'd1;
    end else if (v > 3'd4) begin
      r = 3'd4;
    end
    return r;
  endfunction

endpackage

// File: design/mub_ram.sv
// mub_ram: generic one-write one-read ram with registered read data
// no dependencies
module mub_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/mub_queue.sv
// mub_queue: two-entry fifo between the front and back parts
// no dependencies
module mub_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] entry_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d  = wptr_q ^ do_push;
    rptr_d  = rptr_q ^ do_pop;
    count_d = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/mub_front.sv
// mub_front: config registers, raster and replication counters, command build
// depends on mub_pkg
module mub_front #(
  parameter int unsigned MaxBlocks = mub_pkg::MaxBlocks,
  parameter int unsigned Depth     = MaxBlocks * mub_pkg::BlockSize,
  parameter int unsigned AddrW     = $clog2(Depth)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mub_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mub_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  mub_pkg::in_item_t            in_data_i,
  output logic                         push_o,
  output mub_pkg::cmd_t                cmd_o,
  output logic [AddrW-1:0]             addr_o,
  input  logic                         full_i
);

  localparam int unsigned CntW = AddrW + 1;

  logic [mub_pkg::CfgW-1:0] h_q, v_q, ba_q, bd_q;
  logic [CntW-1:0] load_q, load_d;
  logic [2:0] pcol_q, pcol_d, prow_q, prow_d;
  logic [1:0] bcol_q, bcol_d, brow_q, brow_d;
  logic [1:0] racr_q, racr_d, rdn_q, rdn_d;

  logic [2:0]  hf, vf, ba, bd, bc, br;
  logic        reformat, in_range, accept, pull, wrap, room;
  logic [4:0]  blk;
  logic [10:0] addr_wide;
  logic        w0, w1, w2, w3, u0, u1, u2, u3;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pull       = (in_data_i.mode == mub_pkg::ModePull);

  always_comb begin
    hf = mub_pkg::eff(h_q);
    vf = mub_pkg::eff(v_q);
    ba = mub_pkg::eff(ba_q);
    bd = mub_pkg::eff(bd_q);
    reformat = (hf == 3'd1) && (vf == 3'd1);

    // a block counter beyond a lowered limit reads as the limit minus one
    bc = ({1'b0, bcol_q} < ba) ? {1'b0, bcol_q} : ba - 3'd1;
    br = ({1'b0, brow_q} < bd) ? {1'b0, brow_q} : bd - 3'd1;
    blk = 5'(br) * 5'(ba) + 5'(bc);
    in_range = 32'(blk) < 32'(MaxBlocks);
    addr_wide = {blk, prow_q, pcol_q};

    // reformat chain: pixel_col, block_col, pixel_row, block_row
    w0 = (pcol_q == 3'd7);
    w1 = w0 && (({1'b0, bcol_q} + 3'd1) >= ba);
    w2 = w1 && (prow_q == 3'd7);
    w3 = w2 && (({1'b0, brow_q} + 3'd1) >= bd);
    // upsample chain: repeat_across, pixel_col, repeat_down, pixel_row
    u0 = (({1'b0, racr_q} + 3'd1) >= hf);
    u1 = u0 && (pcol_q == 3'd7);
    u2 = u1 && (({1'b0, rdn_q} + 3'd1) >= vf);
    u3 = u2 && (prow_q == 3'd7);

    wrap = reformat ? w3 : u3;
    room = (load_q < CntW'(Depth));

    load_d = load_q;
    pcol_d = pcol_q;
    bcol_d = bcol_q;
    prow_d = prow_q;
    brow_d = brow_q;
    racr_d = racr_q;
    rdn_d  = rdn_q;

    if (accept && !pull && room) begin
      load_d = load_q + CntW'(1);
    end else if (accept && pull) begin
      if (wrap) begin
        load_d = '0;
        pcol_d = '0;
        bcol_d = '0;
        prow_d = '0;
        brow_d = '0;
        racr_d = '0;
        rdn_d  = '0;
      end else if (reformat) begin
        pcol_d = w0 ? 3'd0 : pcol_q + 3'd1;
        if (w0) begin
          bcol_d = w1 ? 2'd0 : bcol_q + 2'd1;
        end
        if (w1) begin
          prow_d = w2 ? 3'd0 : prow_q + 3'd1;
        end
        if (w2) begin
          brow_d = brow_q + 2'd1;
        end
      end else begin
        racr_d = u0 ? 2'd0 : racr_q + 2'd1;
        if (u0) begin
          pcol_d = u1 ? 3'd0 : pcol_q + 3'd1;
        end
        if (u1) begin
          rdn_d = u2 ? 2'd0 : rdn_q + 2'd1;
        end
        if (u2) begin
          prow_d = prow_q + 3'd1;
        end
      end
    end

    push_o        = accept && (pull || room);
    cmd_o.is_read = pull;
    cmd_o.zero    = reformat && !in_range;
    cmd_o.last    = wrap;
    cmd_o.data    = in_data_i.sample_in;
    if (!pull) begin
      addr_o = load_q[AddrW-1:0];
    end else if (reformat) begin
      addr_o = addr_wide[AddrW-1:0];
    end else begin
      addr_o = AddrW'({prow_q, pcol_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q    <= 3'd1;
      v_q    <= 3'd1;
      ba_q   <= 3'd1;
      bd_q   <= 3'd1;
      load_q <= '0;
      pcol_q <= '0;
      bcol_q <= '0;
      prow_q <= '0;
      brow_q <= '0;
      racr_q <= '0;
      rdn_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mub_pkg::CfgHFactor:      h_q  <= cfg_data_i;
          mub_pkg::CfgVFactor:      v_q  <= cfg_data_i;
          mub_pkg::CfgBlocksAcross: ba_q <= cfg_data_i;
          mub_pkg::CfgBlocksDown:   bd_q <= cfg_data_i;
          default:                  h_q  <= h_q;
        endcase
      end
      load_q <= load_d;
      pcol_q <= pcol_d;
      bcol_q <= bcol_d;
      prow_q <= prow_d;
      brow_q <= brow_d;
      racr_q <= racr_d;
      rdn_q  <= rdn_d;
    end
  end

endmodule

// File: design/mub_back.sv
// mub_back: carries out queued commands against the sample store
// depends on mub_pkg and mub_ram
module mub_back #(
  parameter int unsigned Depth = mub_pkg::MaxBlocks * mub_pkg::BlockSize,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  mub_pkg::cmd_t      cmd_i,
  input  logic [AddrW-1:0]   addr_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mub_pkg::out_item_t out_data_o
);

  logic                         pend_q, pend_zero_q, pend_last_q;
  logic                         out_valid_q, out_valid_d;
  mub_pkg::out_item_t           out_q;
  logic                         rd_ok, we, re;
  logic [mub_pkg::SampleW-1:0]  rdata;

  // a read issues only when its result has a free output slot on arrival
  assign rd_ok = !pend_q && (!out_valid_q || out_ready_i);
  assign pop_o = cmd_valid_i && (!cmd_i.is_read || rd_ok);
  assign we    = pop_o && !cmd_i.is_read;
  assign re    = pop_o && cmd_i.is_read;

  mub_ram #(
    .Width (mub_pkg::SampleW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_i),
    .wdata_i (cmd_i.data),
    .re_i    (re),
    .raddr_i (addr_i),
    .rdata_o (rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (pend_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= re;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      pend_zero_q <= cmd_i.zero;
      pend_last_q <= cmd_i.last;
    end
    if (pend_q) begin
      out_q.sample_out <= pend_zero_q ? '0 : rdata;
      out_q.last       <= pend_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: design/mcu_upsample_block_to_raster.sv
// mcu_upsample_block_to_raster: top level of the mcu raster / upsample block
// depends on mub_pkg, mub_front, mub_queue, mub_back (and mub_ram below it)
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (mode, sample_in)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (sample_out, last)
//  cfg     | input     | cfg_we_i, no wait        | cfg_idx_i, cfg_data_i
//
// a load transaction is taken every cycle while the queue has room
// a pull transaction passes through a store read, then the output register
// the back issues no store read while the data of its last read is pending, which limits the pull rate
// reset clears config to 1 and all counters, the store itself is not cleared
// a stalled output holds its result while the front keeps taking transactions
// until the two-entry queue fills
module mcu_upsample_block_to_raster #(
  parameter int unsigned MaxBlocks = mub_pkg::MaxBlocks
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [mub_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mub_pkg::CfgW-1:0]    cfg_data_i,
  // input transactions
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  mub_pkg::in_item_t           in_data_i,
  // result transactions
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output mub_pkg::out_item_t          out_data_o
);

  localparam int unsigned Depth = MaxBlocks * mub_pkg::BlockSize;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned QW    = AddrW + mub_pkg::CmdW;

  // front side command
  logic               push, full;
  mub_pkg::cmd_t      f_cmd;
  logic [AddrW-1:0]   f_addr;
  // back side command
  logic               q_valid, pop;
  logic [QW-1:0]      q_data;
  mub_pkg::cmd_t      b_cmd;
  logic [AddrW-1:0]   b_addr;

  mub_front #(
    .MaxBlocks (MaxBlocks),
    .Depth     (Depth),
    .AddrW     (AddrW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .cmd_o      (f_cmd),
    .addr_o     (f_addr),
    .full_i     (full)
  );

  // decouples counter updates from store access
  mub_queue #(
    .Width (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({f_addr, f_cmd}),
    .full_o      (full),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .data_o      (q_data)
  );

  assign b_addr = q_data[QW-1:mub_pkg::CmdW];
  assign b_cmd  = mub_pkg::cmd_t'(q_data[mub_pkg::CmdW-1:0]);

  mub_back #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (b_cmd),
    .addr_i      (b_addr),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: verif/tb.sv
// tb: self-checking testbench for mcu_upsample_block_to_raster
// holds a raster/upsample predictor with a scoreboard, drives loads and pulls
// depends on mub_pkg and the rtl of mcu_upsample_block_to_raster only
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 32;     // covers loads still queued in the block
  localparam int unsigned ItemTarget   = 1920;
  localparam int unsigned PullAll      = 4096;   // more than the largest mcu
  localparam int unsigned StoreDepth   = mub_pkg::MaxBlocks * mub_pkg::BlockSize;

  // predicts the raster stream and checks each output transaction against it
  class raster_scoreboard;
    logic [mub_pkg::SampleW-1:0] store [StoreDepth];
    int unsigned                 load_ptr;
    int unsigned                 pix_col, blk_col, pix_row, blk_row, rep_across, rep_down;
    logic [mub_pkg::CfgW-1:0]    regs [4];
    mub_pkg::out_item_t          pending_pixels [$];
    int unsigned                 n_errors;

    function new();
      clear_position();
      for (int i = 0; i < 4; i++) regs[i] = 3'd1;
      n_errors = 0;
    endfunction

    function void clear_position();
      load_ptr   = 0;
      pix_col    = 0;
      blk_col    = 0;
      pix_row    = 0;
      blk_row    = 0;
      rep_across = 0;
      rep_down   = 0;
    endfunction

    function void set_reg(mub_pkg::cfg_idx_e idx, logic [mub_pkg::CfgW-1:0] val);
      regs[idx] = val;
    endfunction

    // zero behaves as one, anything above four as four
    function int unsigned factor(logic [mub_pkg::CfgW-1:0] raw);
      if (raw == 3'd0) return 1;
      if (raw > 3'd4) return 4;
      return int'(raw);
    endfunction

    // step a counter, a value already at or past the limit wraps here
    function bit advance(inout int unsigned ctr, input int unsigned lim);
      if (ctr + 1 >= lim) begin
        ctr = 0;
        return 1'b1;
      end
      ctr++;
      return 1'b0;
    endfunction

    // accepted input transaction; returns the last flag a pull will carry
    function bit take_item(mub_pkg::in_item_t it);
      int unsigned                 hf, vf, ba, bd, bc, br, blk;
      logic [mub_pkg::SampleW-1:0] pixel;
      bit                          wrap;
      mub_pkg::out_item_t          res;
      hf = factor(regs[mub_pkg::CfgHFactor]);
      vf = factor(regs[mub_pkg::CfgVFactor]);
      ba = factor(regs[mub_pkg::CfgBlocksAcross]);
      bd = factor(regs[mub_pkg::CfgBlocksDown]);
      if (mub_pkg::mode_e'(it.mode) == mub_pkg::ModeLoad) begin
        if (load_ptr < StoreDepth) begin
          store[load_ptr] = it.sample_in;
          load_ptr++;
        end
        return 1'b0;
      end
      pixel = '0;
      if (hf == 1 && vf == 1) begin
        bc  = (blk_col < ba) ? blk_col : ba - 1;
        br  = (blk_row < bd) ? blk_row : bd - 1;
        blk = br * ba + bc;
        if (blk < mub_pkg::MaxBlocks) begin
          pixel = store[blk*mub_pkg::BlockSize + pix_row*mub_pkg::BlockSide + pix_col];
        end
        wrap = advance(pix_col, mub_pkg::BlockSide);
        if (wrap) wrap = advance(blk_col, ba);
        if (wrap) wrap = advance(pix_row, mub_pkg::BlockSide);
        if (wrap) wrap = advance(blk_row, bd);
      end else begin
        pixel = store[pix_row*mub_pkg::BlockSide + pix_col];
        wrap = advance(rep_across, hf);
        if (wrap) wrap = advance(pix_col, mub_pkg::BlockSide);
        if (wrap) wrap = advance(rep_down, vf);
        if (wrap) wrap = advance(pix_row, mub_pkg::BlockSide);
      end
      if (wrap) clear_position();
      res.sample_out = pixel;
      res.last       = wrap;
      pending_pixels.push_back(res);
      return wrap;
    endfunction

    function void check_pixel(mub_pkg::out_item_t got);
      mub_pkg::out_item_t want;
      if (pending_pixels.size() == 0) begin
        $error("output transaction with nothing expected: sample_out %02h last %0b",
               got.sample_out, got.last);
        n_errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (got.sample_out !== want.sample_out) begin
        $error("sample_out mismatch: expected %02h, actual %02h",
               want.sample_out, got.sample_out);
        n_errors++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, got.last);
        n_errors++;
      end
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [mub_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [mub_pkg::CfgW-1:0]    cfg_data_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  mub_pkg::in_item_t           in_data_i;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  mub_pkg::out_item_t          out_data_o;

  raster_scoreboard sb;
  int unsigned      tx_idle_pct;
  int unsigned      rx_stall_pct;
  int unsigned      n_items;
  int unsigned      cycle_count = 0;

  mcu_upsample_block_to_raster u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // 10 ns clock
  always #5 clk_i = ~clk_i;

  // run-length guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver side: random back-pressure, rate set per phase
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
  end

  // output monitor: pre-edge values, so the check sees exactly what was accepted
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_pixel(out_data_o);
  end

  // one input transaction, with a random gap in front of it;
  // valid stays high after acceptance unless the next call idles
  task automatic send_item(input mub_pkg::mode_e md, input logic [mub_pkg::SampleW-1:0] smp,
                           output bit is_last);
    mub_pkg::in_item_t it;
    it.mode      = md;
    it.sample_in = smp;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    is_last = sb.take_item(it);
    n_items++;
  endtask

  task automatic load_samples(input int unsigned n);
    bit is_last;
    repeat (n) send_item(mub_pkg::ModeLoad, 8'($urandom_range(255)), is_last);
  endtask

  // pulls up to n pixels, stopping early at the end of the mcu
  task automatic pull_samples(input int unsigned n);
    bit is_last;
    is_last = 1'b0;
    for (int unsigned i = 0; i < n && !is_last; i++) begin
      send_item(mub_pkg::ModePull, 8'($urandom_range(255)), is_last);
    end
  endtask

  // sender holds off until every pixel is back, then lets queued loads retire
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // all four registers, written only once the block is idle
  task automatic write_config(input logic [mub_pkg::CfgW-1:0] h, v, a, d);
    logic [mub_pkg::CfgW-1:0] vals [4];
    settle();
    vals = '{h, v, a, d};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= mub_pkg::cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      sb.set_reg(mub_pkg::cfg_idx_e'(i), vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // none / sender idles / receiver stalls / both, rotating with the phase
  task automatic idle_profile(input int unsigned phase);
    case (phase % 4)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 71; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 71; end
      default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
    endcase
  endtask

  initial begin
    bit                       is_last;
    int unsigned              phase, kind, nload;
    bit                       wide;
    logic [mub_pkg::CfgW-1:0] h_raw, v_raw, a_raw, d_raw;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = mub_pkg::CfgHFactor;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    n_items      = 0;
    sb = new();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset config is one 8x8 block; extreme and walking-one samples,
    // then pulls that only reach the ten entries just written
    send_item(mub_pkg::ModeLoad, 8'h00, is_last);
    send_item(mub_pkg::ModeLoad, 8'hFF, is_last);
    for (int k = 0; k < 8; k++) send_item(mub_pkg::ModeLoad, 8'(8'h01 << k), is_last);
    pull_samples(10);

    // mid-mcu switch to 2x2 blocks with zero factors (acting as one);
    // fills the whole store, the surplus loads are dropped, then the mcu drains
    write_config(3'd0, 3'd0, 3'd2, 3'd2);
    load_samples(252);
    pull_samples(PullAll);

    // every store entry is written from here on, so any pull is legal

    // both factors at their top (7 acts as 4), left mid-mcu
    idle_profile(1);
    write_config(3'd7, 3'd4, 3'd0, 3'd7);
    load_samples(64);
    pull_samples(200);

    // widest reformat, stopped with the block column at 3
    idle_profile(2);
    write_config(3'd1, 3'd1, 3'd4, 3'd7);
    load_samples(200);
    while (!(sb.blk_col == 3 && sb.pix_col >= 4)) begin
      send_item(mub_pkg::ModePull, 8'($urandom_range(255)), is_last);
    end

    // shrink to 2 across: column counter sits past the limit; six blocks,
    // so the last block row lies beyond the store and reads zero
    idle_profile(3);
    write_config(3'd1, 3'd0, 3'd2, 3'd3);
    pull_samples(PullAll);

    // random phases: mostly whole mcus, some broken sequences and noise
    phase = 4;
    while (n_items < ItemTarget) begin
      idle_profile(phase);
      kind = $urandom_range(9);
      wide = ($urandom_range(3) == 0);
      if (kind < 4) begin
        h_raw = 3'($urandom_range(1));
        v_raw = 3'($urandom_range(1));
        a_raw = wide ? 3'($urandom_range(7)) : 3'($urandom_range(1, 2));
        d_raw = wide ? 3'($urandom_range(7)) : 3'($urandom_range(1, 2));
        nload = sb.factor(a_raw) * sb.factor(d_raw);
        nload = (nload > mub_pkg::MaxBlocks ? mub_pkg::MaxBlocks : nload)
                * mub_pkg::BlockSize;
      end else begin
        h_raw = wide ? 3'($urandom_range(7)) : 3'($urandom_range(1, 2));
        v_raw = wide ? 3'($urandom_range(7)) : 3'($urandom_range(1, 2));
        if (sb.factor(h_raw) == 1 && sb.factor(v_raw) == 1) h_raw = 3'd2;
        a_raw = 3'($urandom_range(7));
        d_raw = 3'($urandom_range(7));
        nload = mub_pkg::BlockSize;
      end
      if (kind >= 8) begin
        // noise: any register values, random mix of loads and pulls
        write_config(3'($urandom_range(7)), 3'($urandom_range(7)),
                     3'($urandom_range(7)), 3'($urandom_range(7)));
        repeat (40) begin
          send_item(mub_pkg::mode_e'($urandom_range(1)), 8'($urandom_range(255)), is_last);
        end
      end else begin
        write_config(h_raw, v_raw, a_raw, d_raw);
        if ($urandom_range(3) == 0) nload += $urandom_range(1, 6);
        load_samples(nload);
        pull_samples(PullAll);
        // broken sequence: partial mcu carried into the next setting
        if ($urandom_range(2) == 0) begin
          load_samples($urandom_range(20));
          pull_samples($urandom_range(1, 40));
        end
      end
      phase++;
    end

    settle();
    if (sb.n_errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
